/* hw/rtl/modexp_basis_state_map_unit_macros.svh */
// Assertion macros for the modular-exponentiation basis-state map.
// Used by the RTL files that carry concurrent checks; expects clk_i and rst_ni in scope.
`ifndef MODEXP_BASIS_STATE_MAP_UNIT_MACROS_SVH
`define MODEXP_BASIS_STATE_MAP_UNIT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define MBSM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mbsm check failed");

// Next-cycle implication, disabled while in reset.
`define MBSM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mbsm check failed");

`endif

/* hw/rtl/mbsm_pkg.sv */
// Shared constants, types and helpers of the modexp basis-state map.
// No dependencies; used by every RTL file of the block but the assertion macro header.
package mbsm_pkg;

  // Design constants
  localparam int unsigned INDEX_W   = 64;   // index bits in use (8..64)
  localparam int unsigned MOD_W     = 32;   // modular arithmetic width (4..32)
  localparam int unsigned PROD_W    = 2 * MOD_W;
  localparam int unsigned RED_CNT_W = $clog2(PROD_W);

  // Fixed field widths
  localparam int unsigned IDX_FIELD_W = 64;
  localparam int unsigned TW_W        = 7;
  localparam int unsigned LW_W        = 6;
  localparam int unsigned BASE_W      = 32;
  localparam int unsigned MODU_W      = 32;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 32;

  localparam logic [IDX_FIELD_W-1:0] IDX_MASK =
      {IDX_FIELD_W{1'b1}} >> (IDX_FIELD_W - INDEX_W);

  // Register reset values
  localparam logic [TW_W-1:0]   TOTAL_WIDTH_RST = TW_W'(64);
  localparam logic [LW_W-1:0]   LOW_WIDTH_RST   = LW_W'(32);
  localparam logic [BASE_W-1:0] BASE_RST        = BASE_W'(2);
  localparam logic [MODU_W-1:0] MODULUS_RST     = MODU_W'(15);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TOTAL_WIDTH = 2'd0,
    REG_LOW_WIDTH   = 2'd1,
    REG_BASE        = 2'd2,
    REG_MODULUS     = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_STEP_WAIT,
    ST_FINAL_WAIT,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [TW_W-1:0]   total_width;
    logic [LW_W-1:0]   low_width;
    logic [BASE_W-1:0] base;
    logic [MODU_W-1:0] modulus;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic load;          // capture item and operands
    logic start;         // launch both modular multiplies
    logic commit_step;   // take square (and product if exponent bit set), shift exponent
    logic set_one;       // zero exponent: power is 1
    logic commit_final;  // take final product as the power
    logic load_out;      // move result to output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic e_zero;
    logic e_one;
    logic lane_done;
    logic out_free;
  } status_t;

  // Mask of the kept low index bits; widths of INDEX_W or more keep everything.
  function automatic logic [IDX_FIELD_W-1:0] keep_mask(input logic [TW_W-1:0] tw);
    logic [TW_W-1:0]        keep;
    logic [IDX_FIELD_W-1:0] m;
    keep = (tw > TW_W'(INDEX_W)) ? TW_W'(INDEX_W) : tw;
    if (keep >= TW_W'(IDX_FIELD_W)) begin
      m = {IDX_FIELD_W{1'b1}};
    end else begin
      m = ~({IDX_FIELD_W{1'b1}} << keep);
    end
    return m;
  endfunction

endpackage

/* hw/rtl/mbsm_if.sv */
// Handshake interfaces of the modexp basis-state map: input, output and config write.
// Depends on mbsm_pkg for field widths.
interface mbsm_in_if;
  logic                                valid;
  logic                                ready;
  logic [mbsm_pkg::IDX_FIELD_W-1:0]    state_index;
  modport source (output valid, output state_index, input ready);
  modport sink   (input valid, input state_index, output ready);
endinterface

interface mbsm_out_if;
  logic                                valid;
  logic                                ready;
  logic [mbsm_pkg::IDX_FIELD_W-1:0]    new_index;
  modport source (output valid, output new_index, input ready);
  modport sink   (input valid, input new_index, output ready);
endinterface

interface mbsm_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [mbsm_pkg::CFG_IDX_W-1:0]      index;
  logic [mbsm_pkg::CFG_DATA_W-1:0]     data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/mbsm_modmul.sv */
// Modular multiplier: one registered product, then bit-serial restoring reduction.
// Depends on mbsm_pkg for widths.
module mbsm_modmul (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [mbsm_pkg::MOD_W-1:0]  a_i,
  input  logic [mbsm_pkg::MOD_W-1:0]  b_i,
  input  logic [mbsm_pkg::MOD_W-1:0]  m_i,
  output logic                        done_o,
  output logic [mbsm_pkg::MOD_W-1:0]  res_o
);

  logic [mbsm_pkg::PROD_W-1:0]    prod;
  logic [mbsm_pkg::PROD_W-1:0]    prod_q;
  logic [mbsm_pkg::MOD_W:0]       rem_q, rem_d, rem_shift, rem_sub;
  logic [mbsm_pkg::RED_CNT_W-1:0] cnt_q;
  logic                           busy_q, done_q;
  logic                           last;

  assign prod      = a_i * b_i;
  assign rem_shift = {rem_q[mbsm_pkg::MOD_W-1:0], prod_q[mbsm_pkg::PROD_W-1]};
  assign rem_sub   = rem_shift - {1'b0, m_i};
  assign rem_d     = (rem_shift >= {1'b0, m_i}) ? rem_sub : rem_shift;
  assign last      = (cnt_q == mbsm_pkg::RED_CNT_W'(mbsm_pkg::PROD_W - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + mbsm_pkg::RED_CNT_W'(1);
        if (last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      prod_q <= prod;
      rem_q  <= '0;
    end else if (busy_q) begin
      prod_q <= {prod_q[mbsm_pkg::PROD_W-2:0], 1'b0};
      rem_q  <= rem_d;
    end
  end

  // modulus zero reduces everything to zero
  assign done_o = done_q;
  assign res_o  = (m_i == '0) ? '0 : rem_q[mbsm_pkg::MOD_W-1:0];

endmodule

/* hw/rtl/mbsm_datapath.sv */
// Datapath: index masking, exponent register, two modmul lanes, output register.
// Depends on mbsm_pkg, mbsm_modmul and the assertion macro header.
`include "modexp_basis_state_map_unit_macros.svh"

module mbsm_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  mbsm_pkg::cmd_t                    cmd_i,
  input  mbsm_pkg::cfg_t                    cfg_i,
  input  logic [mbsm_pkg::IDX_FIELD_W-1:0]  in_index_i,
  input  logic                              out_ready_i,
  output mbsm_pkg::status_t                 status_o,
  output logic                              out_valid_o,
  output logic [mbsm_pkg::IDX_FIELD_W-1:0]  out_index_o
);

  logic [mbsm_pkg::IDX_FIELD_W-1:0] masked, masked_q, e_q, out_index_q;
  logic [mbsm_pkg::MOD_W-1:0]       b_q, acc_q, m_q, pw_q, res_a, res_b;
  logic                             done_a, done_b, out_valid_q;

  assign masked = in_index_i & mbsm_pkg::IDX_MASK & mbsm_pkg::keep_mask(cfg_i.total_width);

  // lane A: acc * b (and the final b * acc), lane B: b * b
  mbsm_modmul u_lane_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.start),
    .a_i     (acc_q),
    .b_i     (b_q),
    .m_i     (m_q),
    .done_o  (done_a),
    .res_o   (res_a)
  );

  mbsm_modmul u_lane_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.start),
    .a_i     (b_q),
    .b_i     (b_q),
    .m_i     (m_q),
    .done_o  (done_b),
    .res_o   (res_b)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      masked_q <= masked;
      e_q      <= masked >> cfg_i.low_width;
      b_q      <= cfg_i.base[mbsm_pkg::MOD_W-1:0];
      m_q      <= cfg_i.modulus[mbsm_pkg::MOD_W-1:0];
      acc_q    <= mbsm_pkg::MOD_W'(1);
    end
    if (cmd_i.commit_step) begin
      if (e_q[0]) begin
        acc_q <= res_a;
      end
      b_q <= res_b;
      e_q <= e_q >> 1;
    end
    if (cmd_i.set_one) begin
      pw_q <= mbsm_pkg::MOD_W'(1);
    end
    if (cmd_i.commit_final) begin
      pw_q <= res_a;
    end
    if (cmd_i.load_out) begin
      out_index_q <= (masked_q | mbsm_pkg::IDX_FIELD_W'(pw_q)) & mbsm_pkg::IDX_MASK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign status_o.e_zero    = (e_q == '0);
  assign status_o.e_one     = (e_q == mbsm_pkg::IDX_FIELD_W'(1));
  assign status_o.lane_done = done_a;
  assign status_o.out_free  = !out_valid_q || out_ready_i;
  assign out_valid_o        = out_valid_q;
  assign out_index_o        = out_index_q;

  `MBSM_ASSERT_IMP(a_lanes_in_step, 1'b1, done_a == done_b)
  `MBSM_ASSERT_IMP(a_no_overwrite, cmd_i.load_out, !out_valid_q || out_ready_i)
  `MBSM_ASSERT_IMP(a_step_needs_bits, cmd_i.commit_step, e_q > mbsm_pkg::IDX_FIELD_W'(1))
  `MBSM_ASSERT_NXT(a_power_reduced, cmd_i.commit_final && (m_q != '0), pw_q < m_q)

endmodule

/* hw/rtl/mbsm_ctrl.sv */
// Controller state machine: sequences load, square-and-multiply rounds and result hand-off.
// Depends on mbsm_pkg for state, command and status types.
module mbsm_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  mbsm_pkg::status_t  status_i,
  output mbsm_pkg::cmd_t     cmd_o
);

  mbsm_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mbsm_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mbsm_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = mbsm_pkg::ST_CHECK;
      end
      mbsm_pkg::ST_CHECK: begin
        if (status_i.e_zero) begin
          state_d = mbsm_pkg::ST_EMIT;
        end else if (status_i.e_one) begin
          state_d = mbsm_pkg::ST_FINAL_WAIT;
        end else begin
          state_d = mbsm_pkg::ST_STEP_WAIT;
        end
      end
      mbsm_pkg::ST_STEP_WAIT: begin
        if (status_i.lane_done) state_d = mbsm_pkg::ST_CHECK;
      end
      mbsm_pkg::ST_FINAL_WAIT: begin
        if (status_i.lane_done) state_d = mbsm_pkg::ST_EMIT;
      end
      mbsm_pkg::ST_EMIT: begin
        if (status_i.out_free) state_d = mbsm_pkg::ST_IDLE;
      end
      default: state_d = mbsm_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      mbsm_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      mbsm_pkg::ST_CHECK: begin
        if (status_i.e_zero) begin
          cmd_o.set_one = 1'b1;
        end else begin
          cmd_o.start = 1'b1;
        end
      end
      mbsm_pkg::ST_STEP_WAIT: begin
        cmd_o.commit_step = status_i.lane_done;
      end
      mbsm_pkg::ST_FINAL_WAIT: begin
        cmd_o.commit_final = status_i.lane_done;
      end
      mbsm_pkg::ST_EMIT: begin
        cmd_o.load_out = status_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

/* hw/rtl/modexp_basis_state_map_unit.sv */
// Modexp basis-state map: each index item is masked to total_width bits, the bits above
// low_width form an exponent e, and the result is the masked index ORed with
// base^e mod modulus (e = 0 gives 1 even for modulus 0, else modulus 0 gives 0).
// One item is worked at a time, in one round per bit of e (none when e = 0). Each round
// launches two modular multiplies side by side, each a registered 32x32 product followed
// by one-bit restoring reduction of the 64-bit product, and then commits the results.
// A new item is taken while the previous result still waits in the output register.
// Config writes are taken every cycle and must only be issued while the block is idle.
// Depends on mbsm_pkg, mbsm_if, mbsm_ctrl, mbsm_datapath and mbsm_modmul.
module modexp_basis_state_map_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  mbsm_in_if.sink     in_i,
  mbsm_out_if.source  out_o,
  mbsm_cfg_if.sink    cfg_i
);

  mbsm_pkg::cfg_t    cfg_q;
  mbsm_pkg::cmd_t    cmd;
  mbsm_pkg::status_t status;

  // config register file; always ready
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.total_width <= mbsm_pkg::TOTAL_WIDTH_RST;
      cfg_q.low_width   <= mbsm_pkg::LOW_WIDTH_RST;
      cfg_q.base        <= mbsm_pkg::BASE_RST;
      cfg_q.modulus     <= mbsm_pkg::MODULUS_RST;
    end else if (cfg_i.valid) begin
      case (mbsm_pkg::cfg_reg_e'(cfg_i.index))
        mbsm_pkg::REG_TOTAL_WIDTH: cfg_q.total_width <= cfg_i.data[mbsm_pkg::TW_W-1:0];
        mbsm_pkg::REG_LOW_WIDTH:   cfg_q.low_width   <= cfg_i.data[mbsm_pkg::LW_W-1:0];
        mbsm_pkg::REG_BASE:        cfg_q.base        <= cfg_i.data[mbsm_pkg::BASE_W-1:0];
        mbsm_pkg::REG_MODULUS:     cfg_q.modulus     <= cfg_i.data[mbsm_pkg::MODU_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  mbsm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // masking, exponent, multiply lanes, output register
  mbsm_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cfg_i       (cfg_q),
    .in_index_i  (in_i.state_index),
    .out_ready_i (out_o.ready),
    .status_o    (status),
    .out_valid_o (out_o.valid),
    .out_index_o (out_o.new_index)
  );

endmodule
